### src/stdha_pkg.sv
// ----------------------------------------------------------------------------
// stdha_pkg
// Types, constants and helper functions for the summer time detector.
// ----------------------------------------------------------------------------
package stdha_pkg;

    localparam int HOUR_W  = 5;
    localparam int WDAY_W  = 3;
    localparam int DATE_W  = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 7;
    localparam int SUM_W   = 8;

    localparam logic [HOUR_W-1:0]  HOUR_LAST   = 5'd23;
    localparam logic [HOUR_W-1:0]  HOUR_SWITCH = 5'd3;
    localparam logic [HOUR_W-1:0]  HOUR_EARLY  = 5'd1;
    localparam logic [WDAY_W-1:0]  WDAY_FIRST  = 3'd1;
    localparam logic [WDAY_W-1:0]  WDAY_LAST   = 3'd7;
    localparam logic [DATE_W-1:0]  DATE_FIRST  = 5'd1;
    localparam logic [DATE_W-1:0]  DATE_MAX    = 5'd31;
    localparam logic [DATE_W-1:0]  DATE_FEB    = 5'd28;
    localparam logic [MONTH_W-1:0] MON_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR     = 4'd3;
    localparam logic [MONTH_W-1:0] MON_OCT     = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV     = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC     = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_LAST   = 7'd99;
    localparam logic [YEAR_W-1:0]  YEAR_CENT   = 7'd100;

    // Day-of-week offsets of March 31 and October 31 (7000 + 31 + month term, mod 7).
    localparam logic [SUM_W-1:0] MAR_OFS = 8'd5;
    localparam logic [SUM_W-1:0] OCT_OFS = 8'd2;

    localparam logic [DATE_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DATE_W-1:0]  date;
        logic [WDAY_W-1:0]  weekday;
        logic [HOUR_W-1:0]  hour;
    } t_cal;

    function automatic logic [DATE_W-1:0] days_in(input logic [MONTH_W-1:0] month);
        logic [MONTH_W-1:0] idx;
        idx = month - MON_JAN;
        if (month >= MON_JAN && month <= MON_DEC) begin
            return MONTH_LEN[idx];
        end
        return DATE_MAX;
    endfunction

    // Residue mod 7 by folding base-8 digits, since 8 is 1 mod 7.
    function automatic logic [2:0] mod7(input logic [SUM_W-1:0] x);
        logic [4:0] a;
        logic [3:0] b;
        a = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        b = 4'(a[4:3]) + 4'(a[2:0]);
        if (b >= 4'd7) begin
            b = b - 4'd7;
        end
        return b[2:0];
    endfunction

endpackage

### src/summer_time_detect_and_hour_advance.sv
// ----------------------------------------------------------------------------
// summer_time_detect_and_hour_advance
// Decides whether summer time applies to a standard-time reading and
// advances the reading by one hour when it does.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: hour, weekday, date, month, year
//  m_axis    | out       | tdata: out_hour .. out_year, tuser: dst_active
//
//  Four register stages: year sum, last Sunday dates, summer time flag, advance.
//  The pipeline accepts and returns one request per cycle while m_axis_tready stays high.
//  Each stage holds its data while the next one is full and stalled.
//  Reset clears the valid bits of all stages.
// ----------------------------------------------------------------------------
module summer_time_detect_and_hour_advance
    import stdha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // hour[4:0], weekday[7:5], date[12:8],
                                       // month[16:13], year[23:17]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_hour[4:0], out_weekday[7:5],
                                       // out_date[12:8], out_month[16:13],
                                       // out_year[23:17]
    output logic        m_axis_tuser   // dst_active[0]
);

    logic              r1_v, r2_v, r3_v, r4_v;
    logic              rdy1, rdy2, rdy3, rdy4;
    t_cal              r1_cal, r2_cal, r3_cal, r4_cal;
    logic [SUM_W-1:0]  r1_sum;
    logic [DATE_W-1:0] r2_mar, r2_oct;
    logic              r2_last, r3_last, r3_dst, r4_dst;

    t_cal              in_cal;
    logic [SUM_W-1:0]  n_sum;
    logic [DATE_W-1:0] n_mar, n_oct;
    logic              n_last, n_dst;
    t_cal              n_out;

    assign in_cal = t_cal'(s_axis_tdata);

    assign rdy4 = !r4_v || m_axis_tready;
    assign rdy3 = !r3_v || rdy4;
    assign rdy2 = !r2_v || rdy3;
    assign rdy1 = !r1_v || rdy2;
    assign s_axis_tready = rdy1;

    always_comb begin
        n_sum = SUM_W'(in_cal.year) + SUM_W'(in_cal.year[YEAR_W-1:2])
              - SUM_W'(in_cal.year >= YEAR_CENT);
    end

    always_comb begin
        n_mar = DATE_MAX - DATE_W'(mod7(r1_sum + MAR_OFS));
        n_oct = DATE_MAX - DATE_W'(mod7(r1_sum + OCT_OFS));
        if (r1_cal.year[1:0] != 2'd0) begin
            n_last = (r1_cal.date == days_in(r1_cal.month))
                  || (r1_cal.month == MON_FEB && r1_cal.date == DATE_FEB);
        end else begin
            n_last = (r1_cal.date == days_in(r1_cal.month));
        end
    end

    always_comb begin
        n_dst = (r2_cal.month > MON_MAR && r2_cal.month < MON_OCT)
             || (r2_cal.month == MON_MAR && r2_cal.date > r2_mar)
             || (r2_cal.month == MON_MAR && r2_cal.date == r2_mar
                 && r2_cal.hour >= HOUR_SWITCH)
             || (r2_cal.month == MON_OCT && r2_cal.date < r2_oct)
             || (r2_cal.month == MON_OCT && r2_cal.date == r2_oct
                 && (r2_cal.hour <= HOUR_EARLY || r2_cal.hour == HOUR_LAST));
    end

    always_comb begin
        n_out = r3_cal;
        if (r3_dst) begin
            if (r3_cal.hour == HOUR_LAST) begin
                n_out.hour    = '0;
                n_out.weekday = (r3_cal.weekday == WDAY_LAST) ? WDAY_FIRST
                              : r3_cal.weekday + WDAY_FIRST;
                if (r3_last) begin
                    n_out.date = DATE_FIRST;
                    if (r3_cal.month == MON_DEC) begin
                        n_out.month = MON_JAN;
                        n_out.year  = (r3_cal.year == YEAR_LAST) ? '0
                                    : r3_cal.year + YEAR_W'(1);
                    end else begin
                        n_out.month = r3_cal.month + MONTH_W'(1);
                    end
                end else begin
                    n_out.date = r3_cal.date + DATE_W'(1);
                end
            end else begin
                n_out.hour = r3_cal.hour + HOUR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= s_axis_tvalid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
            if (rdy4) r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_cal <= in_cal;
            r1_sum <= n_sum;
        end
        if (rdy2) begin
            r2_cal  <= r1_cal;
            r2_mar  <= n_mar;
            r2_oct  <= n_oct;
            r2_last <= n_last;
        end
        if (rdy3) begin
            r3_cal  <= r2_cal;
            r3_last <= r2_last;
            r3_dst  <= n_dst;
        end
        if (rdy4) begin
            r4_cal <= n_out;
            r4_dst <= r3_dst;
        end
    end

    assign m_axis_tvalid = r4_v;
    assign m_axis_tdata  = 24'(r4_cal);
    assign m_axis_tuser  = r4_dst;

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && rdy4 && !r3_dst) |=> (r4_cal == $past(r3_cal)))
        else $error("Reading changed although summer time does not apply.");

    a_sunday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_v |-> (r2_mar >= 5'd25 && r2_oct >= 5'd25))
        else $error("Last Sunday date out of the last week of the month.");

    a_dst_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_v && r4_dst) |-> (r4_cal.month >= MON_MAR && r4_cal.month <= MON_NOV))
        else $error("Summer time flagged outside March to November.");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && !rdy3) |=> (r2_v && $stable(r2_cal)))
        else $error("Stalled stage lost or changed its request.");

endmodule

### tb/summer_time_detect_and_hour_advance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// summer_time_detect_and_hour_advance_tb
// Drives calendar readings into the summer time detector and checks every
// result against an in-bench model of the last-Sunday rule and the one-hour
// advance. It starts with hand-picked change days and rollovers, then sends
// mostly random readings aimed at the change days and month ends. Random
// gaps are applied on both stream sides, with one long output stall.
// ----------------------------------------------------------------------------
import stdha_pkg::*;

typedef struct packed {
    logic dst;
    t_cal cal;
} t_dst_result;

class dst_scoreboard;
    t_dst_result expected_results[$];
    int          failures;

    function new();
        failures = 0;
    endfunction

    // Date of the last Sunday of March or October of year 2000+year.
    static function int last_sunday(int month, int year);
        int mm;
        int dow;
        mm  = month - 2;
        dow = (7000 + 31 + year + year / 4 - year / 100 + year / 400 + (31 * mm) / 12) % 7;
        return 31 - dow;
    endfunction

    static function int month_days(int month);
        if (month == int'(MON_FEB)) begin
            return 29;
        end
        if (month == 4 || month == 6 || month == 9 || month == int'(MON_NOV)) begin
            return 30;
        end
        return 31;
    endfunction

    static function t_dst_result advance_reading(t_cal r);
        t_dst_result e;
        int          mar_sun;
        int          oct_sun;
        logic        month_end;
        mar_sun = last_sunday(int'(MON_MAR), int'(r.year));
        oct_sun = last_sunday(int'(MON_OCT), int'(r.year));
        e.cal = r;
        e.dst = (r.month > MON_MAR && r.month < MON_OCT) ||
                (r.month == MON_MAR && int'(r.date) > mar_sun) ||
                (r.month == MON_MAR && int'(r.date) == mar_sun && r.hour >= HOUR_SWITCH) ||
                (r.month == MON_OCT && int'(r.date) < oct_sun) ||
                (r.month == MON_OCT && int'(r.date) == oct_sun &&
                 (r.hour <= HOUR_EARLY || r.hour == HOUR_LAST));
        if (e.dst) begin
            if (r.hour == HOUR_LAST) begin
                e.cal.hour    = '0;
                e.cal.weekday = (r.weekday == WDAY_LAST) ? WDAY_FIRST : r.weekday + 3'd1;
                month_end = (int'(r.date) == month_days(int'(r.month))) ||
                            (r.year[1:0] != 2'd0 && r.month == MON_FEB && r.date == DATE_FEB);
                if (month_end) begin
                    e.cal.date = DATE_FIRST;
                    if (r.month == MON_DEC) begin
                        e.cal.month = MON_JAN;
                        e.cal.year  = (r.year == YEAR_LAST) ? 7'd0 : r.year + 7'd1;
                    end else begin
                        e.cal.month = r.month + 4'd1;
                    end
                end else begin
                    e.cal.date = r.date + 5'd1;
                end
            end else begin
                e.cal.hour = r.hour + 5'd1;
            end
        end
        return e;
    endfunction

    function void note_reading(t_cal r);
        expected_results.push_back(advance_reading(r));
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            failures++;
        end
    endfunction

    function void check_result(logic dst, t_cal got);
        t_dst_result e;
        if (expected_results.size() == 0) begin
            $error("result with no request waiting: dst_active %0d, tdata %h", dst, got);
            failures++;
            return;
        end
        e = expected_results.pop_front();
        compare_field("dst_active", int'(e.dst), int'(dst));
        compare_field("out_hour", int'(e.cal.hour), int'(got.hour));
        compare_field("out_weekday", int'(e.cal.weekday), int'(got.weekday));
        compare_field("out_date", int'(e.cal.date), int'(got.date));
        compare_field("out_month", int'(e.cal.month), int'(got.month));
        compare_field("out_year", int'(e.cal.year), int'(got.year));
    endfunction

    function int pending();
        return expected_results.size();
    endfunction
endclass

module summer_time_detect_and_hour_advance_tb;

    localparam int RANDOM_READINGS = 1450;
    localparam int HOLD_AFTER      = 700;
    localparam int HOLD_CYCLES     = 300;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    dst_scoreboard sb;
    int            readings_in = 0;
    int            idle_cycles = 0;
    bit            hold_busy   = 0;
    bit            hold_done   = 0;

    summer_time_detect_and_hour_advance u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cal make_reading(int h, int w, int d, int m, int y);
        t_cal r;
        r.hour    = 5'(h);
        r.weekday = 3'(w);
        r.date    = 5'(d);
        r.month   = 4'(m);
        r.year    = 7'(y);
        return r;
    endfunction

    function automatic t_cal random_reading();
        t_cal r;
        int   kind;
        int   sun;
        int   hot_hours[6] = '{0, 1, 2, 3, 22, 23};
        kind = $urandom_range(0, 9);
        r = t_cal'(24'($urandom));
        if (kind >= 3 && kind <= 5) begin
            // Around the change days of March and October.
            r.month = $urandom_range(0, 1) ? MON_MAR : MON_OCT;
            r.year  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(100, 127))
                                                  : 7'($urandom_range(0, 99));
            sun     = sb.last_sunday(int'(r.month), int'(r.year));
            r.date  = 5'(sun - 1 + int'($urandom_range(0, 2)));
            r.hour  = ($urandom_range(0, 3) != 0) ? 5'(hot_hours[$urandom_range(0, 5)])
                                                  : 5'($urandom_range(0, 23));
            r.weekday = 3'($urandom_range(1, 7));
        end else if (kind >= 6 && kind <= 8) begin
            // Summer evenings, often on the last day of the month.
            r.month = 4'($urandom_range(3, 10));
            r.year  = 7'($urandom_range(0, 99));
            r.date  = $urandom_range(0, 1) ? 5'(sb.month_days(int'(r.month)))
                                           : 5'($urandom_range(1, 31));
            r.hour  = ($urandom_range(0, 9) < 7) ? HOUR_LAST : 5'($urandom_range(0, 23));
            r.weekday = 3'($urandom_range(0, 7));
        end else if (kind == 9) begin
            r = make_reading($urandom_range(0, 23), $urandom_range(1, 7),
                             $urandom_range(1, 31), $urandom_range(1, 12),
                             $urandom_range(0, 99));
        end
        return r;
    endfunction

    task automatic send_reading(input t_cal r);
        int gap;
        gap = hold_busy ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Every accepted request is noted before any result of the same edge is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_reading(t_cal'(s_axis_tdata));
                readings_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tuser, t_cal'(m_axis_tdata));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int run;
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!hold_done && readings_in >= HOLD_AFTER) begin
                hold_busy = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_busy = 1'b0;
                hold_done = 1'b1;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 100)
                                                  : $urandom_range(1, 8);
                m_axis_tready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        t_cal directed[$];
        sb = new();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes and months outside the calendar.
        directed.push_back(make_reading(0, 1, 1, 1, 0));
        directed.push_back(make_reading(31, 7, 31, 15, 127));
        directed.push_back(make_reading(23, 0, 0, 0, 0));
        directed.push_back(make_reading(23, 3, 15, 13, 50));
        // The March change day of 2024 and the evening before it.
        directed.push_back(make_reading(2, 7, 31, 3, 24));
        directed.push_back(make_reading(3, 7, 31, 3, 24));
        directed.push_back(make_reading(23, 7, 31, 3, 24));
        directed.push_back(make_reading(23, 6, 30, 3, 24));
        // The October change day of 2024 and its neighbors.
        directed.push_back(make_reading(0, 7, 27, 10, 24));
        directed.push_back(make_reading(1, 7, 27, 10, 24));
        directed.push_back(make_reading(2, 7, 27, 10, 24));
        directed.push_back(make_reading(22, 7, 27, 10, 24));
        directed.push_back(make_reading(23, 7, 27, 10, 24));
        directed.push_back(make_reading(23, 6, 26, 10, 24));
        directed.push_back(make_reading(5, 1, 28, 10, 24));
        // Month ends and out-of-range hours, weekdays and dates in summer.
        directed.push_back(make_reading(23, 6, 30, 9, 23));
        directed.push_back(make_reading(23, 4, 31, 8, 99));
        directed.push_back(make_reading(31, 2, 15, 6, 10));
        directed.push_back(make_reading(24, 2, 15, 6, 10));
        directed.push_back(make_reading(23, 0, 12, 7, 5));
        directed.push_back(make_reading(23, 5, 31, 6, 33));
        directed.push_back(make_reading(23, 5, 0, 5, 33));
        directed.push_back(make_reading(10, 3, 20, 4, 127));
        directed.push_back(make_reading(5, 1, 31, 3, 100));

        foreach (directed[i]) begin
            send_reading(directed[i]);
        end
        repeat (RANDOM_READINGS) send_reading(random_reading());
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/stdha_pkg.sv
src/summer_time_detect_and_hour_advance.sv
tb/summer_time_detect_and_hour_advance_tb.sv
